FILE: rtl/htlp_pkg.sv
// Shared types and constants for the linear-probing hash table.
package htlp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = IDX_W + 1;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam logic [0:0] OP_INSERT = 1'b0;
  localparam logic [0:0] OP_SEARCH = 1'b1;

  localparam logic [2:0] ST_HOME      = 3'd0;
  localparam logic [2:0] ST_CHAINED   = 3'd1;
  localparam logic [2:0] ST_DISPLACED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // Write commands into the slot store: one full entry write and one link write.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             has_next;
    logic [IDX_W-1:0] next;
    logic             link_we;
    logic [IDX_W-1:0] link_addr;
    logic [IDX_W-1:0] link_next;
  } store_cmd_t;

endpackage

FILE: rtl/hash_table_linear_probe_chain_replace.sv
// Hash table with linear probing, chaining and replacement: top-level sequencer.
//
// Usage: drive opcode, record_key and record_value and raise start while busy
// is low; the item is taken at that clock edge and busy rises. Opcode 0
// inserts the key with its value, opcode 1 searches for the key. Exactly one
// result comes back per item on status, slot_index and found_value, marked by
// result_valid for a single cycle; the receiver cannot stall it.
// The modulo of a key by table_size goes through one bit-serial remainder
// unit. A search walks the chain from the home slot, reading and comparing
// one link at a time. An insert into a free home slot finishes after the
// first remainder; other inserts run a second remainder on the occupant's
// key, probe up to 16 slots and walk up to 16 chain links.
// The table_size register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce. 0 reads as 1 and values above 16 as 16.
// Synchronous reset empties the table at once, sets table_size to 16 and
// returns the sequencer to idle. A new item is taken the cycle after the
// result, or in the result cycle itself since busy is already low then.
module hash_table_linear_probe_chain_replace (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [0:0]                         opcode,
  input  logic [htlp_pkg::KEY_W-1:0]         record_key,
  input  logic [htlp_pkg::VAL_W-1:0]         record_value,
  input  logic                               cfg_we,
  input  logic [htlp_pkg::SIZE_W-1:0]        cfg_wdata,
  output logic                               result_valid,
  output logic [2:0]                         status,
  output logic [htlp_pkg::IDX_W-1:0]         slot_index,
  output logic [htlp_pkg::VAL_W-1:0]         found_value
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MODK  = 12'b000000000010,
    S_HRD   = 12'b000000000100,
    S_HCAP  = 12'b000000001000,
    S_MODO  = 12'b000000010000,
    S_PROBE = 12'b000000100000,
    S_MOVEW = 12'b000001000000,
    S_PRED  = 12'b000010000000,
    S_HOMEW = 12'b000100000000,
    S_TAIL  = 12'b001000000000,
    S_SRD   = 12'b010000000000,
    S_SCMP  = 12'b100000000000
  } state_t;

  localparam logic [htlp_pkg::SIZE_W-1:0] SIZE_W_ONE = 1;

  state_t state;

  logic [0:0]                      op;
  logic [htlp_pkg::KEY_W-1:0]      key;
  logic [htlp_pkg::VAL_W-1:0]      value;
  logic [htlp_pkg::SIZE_W-1:0]     table_size;
  logic [htlp_pkg::IDX_W-1:0]      home;
  logic [htlp_pkg::IDX_W-1:0]      free_slot;
  logic [htlp_pkg::IDX_W-1:0]      ptr;
  logic [htlp_pkg::SIZE_W-1:0]     cnt;
  logic                            displace;
  logic [htlp_pkg::KEY_W-1:0]      hkey;
  logic [htlp_pkg::VAL_W-1:0]      hvalue;
  logic                            hhas_next;
  logic [htlp_pkg::IDX_W-1:0]      hnext;

  logic                            mod_go;
  logic [htlp_pkg::KEY_W-1:0]      mod_dividend;
  logic                            mod_done;
  logic [htlp_pkg::IDX_W-1:0]      mod_rem;

  htlp_pkg::store_cmd_t            cmd;
  logic [htlp_pkg::KEY_W-1:0]      rd_key;
  logic [htlp_pkg::VAL_W-1:0]      rd_value;
  logic                            rd_used;
  logic                            rd_has_next;
  logic [htlp_pkg::IDX_W-1:0]      rd_next;

  logic [htlp_pkg::SIZE_W-1:0]     ptr_inc;
  logic [htlp_pkg::IDX_W-1:0]      ptr_wrap;
  logic [htlp_pkg::SIZE_W-1:0]     home_inc;
  logic [htlp_pkg::IDX_W-1:0]      home_wrap;
  logic [htlp_pkg::SIZE_W-1:0]     size_next;

  assign busy = (state != S_IDLE);

  assign ptr_inc   = {1'b0, ptr} + 1'b1;
  assign ptr_wrap  = (ptr_inc == table_size) ? '0 : ptr_inc[htlp_pkg::IDX_W-1:0];
  assign home_inc  = {1'b0, home} + 1'b1;
  assign home_wrap = (home_inc == table_size) ? '0 : home_inc[htlp_pkg::IDX_W-1:0];

  always_comb begin
    size_next = cfg_wdata;
    if (cfg_wdata == '0) begin
      size_next = SIZE_W_ONE;
    end else if (cfg_wdata > htlp_pkg::SIZE_W'(htlp_pkg::TABLE_DEPTH)) begin
      size_next = htlp_pkg::SIZE_W'(htlp_pkg::TABLE_DEPTH);
    end
  end

  assign mod_go       = (state == S_IDLE && start) || (state == S_HCAP);
  assign mod_dividend = (state == S_IDLE) ? record_key : rd_key;

  htlp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .go       (mod_go),
    .dividend (mod_dividend),
    .divisor  (table_size),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  htlp_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_addr     (ptr),
    .rd_key      (rd_key),
    .rd_value    (rd_value),
    .rd_used     (rd_used),
    .rd_has_next (rd_has_next),
    .rd_next     (rd_next)
  );

  // Store writes issued by the sequencer.
  always_comb begin
    cmd           = '0;
    cmd.key       = key;
    cmd.value     = value;
    cmd.link_next = free_slot;
    unique case (state)
      S_MOVEW: begin
        cmd.we       = 1'b1;
        cmd.addr     = free_slot;
        cmd.key      = hkey;
        cmd.value    = hvalue;
        cmd.has_next = hhas_next;
        cmd.next     = hnext;
      end
      S_PRED: begin
        cmd.link_we   = rd_has_next && (rd_next == home);
        cmd.link_addr = ptr;
      end
      S_HOMEW: begin
        cmd.we   = 1'b1;
        cmd.addr = home;
      end
      S_TAIL: begin
        if (!rd_has_next || cnt == htlp_pkg::SIZE_W'(htlp_pkg::TABLE_DEPTH)) begin
          cmd.we        = 1'b1;
          cmd.addr      = free_slot;
          cmd.link_we   = 1'b1;
          cmd.link_addr = ptr;
        end
      end
      S_HRD: begin
        if (!rd_used) begin
          cmd.we   = 1'b1;
          cmd.addr = home;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      table_size   <= htlp_pkg::SIZE_W'(htlp_pkg::TABLE_DEPTH);
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        table_size <= size_next;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= opcode;
            key   <= record_key;
            value <= record_value;
            state <= S_MODK;
          end
        end
        S_MODK: begin
          if (mod_done) begin
            home <= mod_rem;
            ptr  <= mod_rem;
            cnt  <= '0;
            if (op == htlp_pkg::OP_SEARCH) begin
              state <= S_SRD;
            end else begin
              state <= S_HRD;
            end
          end
        end
        S_HRD: begin
          // The home flags are read at once; an occupied home also has its key fetched.
          if (!rd_used) begin
            status       <= htlp_pkg::ST_HOME;
            slot_index   <= home;
            found_value  <= '0;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_HCAP;
          end
        end
        S_HCAP: begin
          hkey      <= rd_key;
          hvalue    <= rd_value;
          hhas_next <= rd_has_next;
          hnext     <= rd_next;
          state     <= S_MODO;
        end
        S_MODO: begin
          if (mod_done) begin
            cnt <= '0;
            if (mod_rem != home) begin
              displace <= 1'b1;
              ptr      <= mod_rem;
            end else begin
              displace <= 1'b0;
              ptr      <= home_wrap;
            end
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!rd_used) begin
            free_slot <= ptr;
            cnt       <= '0;
            if (displace) begin
              state <= S_MOVEW;
            end else begin
              ptr   <= home;
              state <= S_TAIL;
            end
          end else if (cnt == table_size - 1'b1) begin
            status       <= htlp_pkg::ST_FULL;
            slot_index   <= '0;
            found_value  <= '0;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
            ptr <= ptr_wrap;
          end
        end
        S_MOVEW: begin
          // The predecessor search starts at the moved entry's own home.
          ptr   <= mod_rem;
          cnt   <= '0;
          state <= S_PRED;
        end
        S_PRED: begin
          if (!rd_has_next || rd_next == home ||
              cnt == htlp_pkg::SIZE_W'(htlp_pkg::TABLE_DEPTH - 1)) begin
            state <= S_HOMEW;
          end else begin
            ptr <= rd_next;
            cnt <= cnt + 1'b1;
          end
        end
        S_HOMEW: begin
          status       <= htlp_pkg::ST_DISPLACED;
          slot_index   <= home;
          found_value  <= '0;
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        S_TAIL: begin
          if (!rd_has_next || cnt == htlp_pkg::SIZE_W'(htlp_pkg::TABLE_DEPTH)) begin
            status       <= htlp_pkg::ST_CHAINED;
            slot_index   <= free_slot;
            found_value  <= '0;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            ptr <= rd_next;
            cnt <= cnt + 1'b1;
          end
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_used && rd_key == key) begin
            status       <= htlp_pkg::ST_FOUND;
            slot_index   <= ptr;
            found_value  <= rd_value;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (!rd_has_next ||
                       cnt == htlp_pkg::SIZE_W'(htlp_pkg::TABLE_DEPTH - 1)) begin
            status       <= htlp_pkg::ST_NOT_FOUND;
            slot_index   <= '0;
            found_value  <= '0;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            ptr   <= rd_next;
            cnt   <= cnt + 1'b1;
            state <= S_SRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while the sequencer is still working");

  a_result_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= htlp_pkg::ST_NOT_FOUND))
    else $error("result status out of range");
`endif

endmodule

FILE: rtl/htlp_mod.sv
// Bit-serial restoring remainder unit: 32-bit dividend modulo a small divisor.
module htlp_mod (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [htlp_pkg::KEY_W-1:0]        dividend,
  input  logic [htlp_pkg::SIZE_W-1:0]       divisor,
  output logic                              done,
  output logic [htlp_pkg::IDX_W-1:0]        rem
);

  logic                               run;
  logic [$clog2(htlp_pkg::KEY_W)-1:0] cnt;
  logic [htlp_pkg::KEY_W-1:0]         quo;
  logic [htlp_pkg::SIZE_W-1:0]        trial;
  logic [htlp_pkg::SIZE_W-1:0]        diff;

  assign trial = {rem, quo[htlp_pkg::KEY_W-1]};
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One dividend bit enters the partial remainder each cycle.
  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
    end else if (run) begin
      quo <= {quo[htlp_pkg::KEY_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem <= diff[htlp_pkg::IDX_W-1:0];
      end else begin
        rem <= trial[htlp_pkg::IDX_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/htlp_store.sv
// Slot store: key and value memories plus occupancy and chain link flags.
module htlp_store (
  input  logic                          clk,
  input  logic                          rst,
  input  htlp_pkg::store_cmd_t          cmd,
  input  logic [htlp_pkg::IDX_W-1:0]    rd_addr,
  output logic [htlp_pkg::KEY_W-1:0]    rd_key,
  output logic [htlp_pkg::VAL_W-1:0]    rd_value,
  output logic                          rd_used,
  output logic                          rd_has_next,
  output logic [htlp_pkg::IDX_W-1:0]    rd_next
);

  logic [htlp_pkg::KEY_W-1:0] keys   [htlp_pkg::TABLE_DEPTH];
  logic [htlp_pkg::VAL_W-1:0] values [htlp_pkg::TABLE_DEPTH];
  logic [htlp_pkg::TABLE_DEPTH-1:0] used;
  logic [htlp_pkg::TABLE_DEPTH-1:0] has_next;
  logic [htlp_pkg::IDX_W-1:0] nexts  [htlp_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      keys[cmd.addr]   <= cmd.key;
      values[cmd.addr] <= cmd.value;
    end
    rd_key   <= keys[rd_addr];
    rd_value <= values[rd_addr];
  end

  // The link write comes last so that it wins over an entry write.
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      has_next <= '0;
    end else begin
      if (cmd.we) begin
        used[cmd.addr]     <= 1'b1;
        has_next[cmd.addr] <= cmd.has_next;
      end
      if (cmd.link_we) begin
        has_next[cmd.link_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      nexts[cmd.addr] <= cmd.next;
    end
    if (cmd.link_we) begin
      nexts[cmd.link_addr] <= cmd.link_next;
    end
  end

  assign rd_used     = used[rd_addr];
  assign rd_has_next = has_next[rd_addr];
  assign rd_next     = nexts[rd_addr];

endmodule
